### rtl/core/pee_pkg.sv
// Package for the prefix expression evaluator: symbol codes, error codes,
// controller states and the command/status structs. No dependencies.
package pee_pkg;

  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_NINE  = 8'h39;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_MUL   = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_UNDER  = 3'd1,
    ERR_DIV0   = 3'd2,
    ERR_SYMBOL = 3'd3,
    ERR_SAT    = 3'd4,
    ERR_FULL   = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    OP_DIGIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic mul_step;
    logic div_step;
    logic fin;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic last;
    logic div_done;
    logic mul_done;
    logic div_zero;
    logic short_stack;
  } sts_t;

endpackage

### rtl/core/pee_ctrl.sv
// Controller FSM of the prefix expression evaluator.
// Depends on pee_pkg.
module pee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_free,
  input  pee_pkg::sts_t sts,
  output pee_pkg::cmd_t cmd,
  output logic          busy
);

  pee_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pee_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pee_pkg::ST_IDLE: if (in_fire) state_nxt = pee_pkg::ST_READ;
      pee_pkg::ST_READ: state_nxt = pee_pkg::ST_EXEC;
      pee_pkg::ST_EXEC: begin
        if (sts.op == pee_pkg::OP_MUL && !sts.short_stack) state_nxt = pee_pkg::ST_MUL;
        else if (sts.op == pee_pkg::OP_DIV && !sts.short_stack && !sts.div_zero)
          state_nxt = pee_pkg::ST_DIV;
        else state_nxt = pee_pkg::ST_FIN;
      end
      pee_pkg::ST_MUL: if (sts.mul_done) state_nxt = pee_pkg::ST_FIN;
      pee_pkg::ST_DIV: if (sts.div_done) state_nxt = pee_pkg::ST_FIN;
      pee_pkg::ST_FIN: state_nxt = sts.last ? pee_pkg::ST_OUT : pee_pkg::ST_IDLE;
      pee_pkg::ST_OUT: if (out_free) state_nxt = pee_pkg::ST_IDLE;
      default: state_nxt = pee_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      pee_pkg::ST_IDLE: begin busy = 1'b0; cmd.load = in_fire; end
      pee_pkg::ST_READ: cmd.rd = 1'b1;
      pee_pkg::ST_EXEC: cmd.exec = 1'b1;
      pee_pkg::ST_MUL: cmd.mul_step = 1'b1;
      pee_pkg::ST_DIV: cmd.div_step = 1'b1;
      pee_pkg::ST_FIN: cmd.fin = 1'b1;
      pee_pkg::ST_OUT: cmd.out_done = out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/pee_dp.sv
// Datapath: value stack, Q format add/sub, partial-product multiplier, radix-2 divider.
// Depends on pee_pkg.
module pee_dp #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             symbol,
  input  logic                   last,
  input  pee_pkg::cmd_t          cmd,
  output pee_pkg::sts_t          sts,
  output logic signed [VALUE_WIDTH-1:0] res_value,
  output logic [2:0]             res_error
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int W  = VALUE_WIDTH;
  localparam int HW = (W + 1) / 2;
  localparam int PW = 2 * W;
  localparam int NW = W + FRAC_BITS;
  localparam int IW = $clog2(NW + 1);
  localparam int DW = NW + 4;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0] cnt_r;
  logic [2:0] err_r;
  logic [7:0] sym_r;
  logic last_r;
  logic [W-1:0] op1_r, op2_r, res_r;
  logic res_ok_r;
  logic neg_r;
  logic [W-1:0] ma_r, mb_r;
  logic [PW-1:0] acc_r;
  logic [1:0] mstep_r;
  logic [NW-1:0] num_r;
  logic [W:0] rem_r;
  logic [IW-1:0] dcnt_r;
  logic [W-1:0] out_value_r;
  logic [2:0] out_error_r;

  pee_pkg::op_t op;
  always_comb begin
    if (sym_r >= pee_pkg::SYM_ZERO && sym_r <= pee_pkg::SYM_NINE) op = pee_pkg::OP_DIGIT;
    else begin
      case (sym_r)
        pee_pkg::SYM_PLUS:  op = pee_pkg::OP_ADD;
        pee_pkg::SYM_MINUS: op = pee_pkg::OP_SUB;
        pee_pkg::SYM_MUL:   op = pee_pkg::OP_MUL;
        pee_pkg::SYM_DIV:   op = pee_pkg::OP_DIV;
        default:            op = pee_pkg::OP_BAD;
      endcase
    end
  end

  logic short_stack, full;
  assign short_stack = cnt_r < CW'(2);
  assign full = cnt_r >= CW'(STACK_DEPTH);

  // digit value with saturation check
  logic [DW-1:0] dig_ext;
  logic dig_sat;
  assign dig_ext = DW'(sym_r[3:0] - 4'd0) << FRAC_BITS;
  assign dig_sat = dig_ext > DW'(VMAX);

  logic [W:0] sum_w, dif_w;
  assign sum_w = {op1_r[W-1], op1_r} + {op2_r[W-1], op2_r};
  assign dif_w = {op1_r[W-1], op1_r} - {op2_r[W-1], op2_r};

  logic [W-1:0] mag1, mag2;
  assign mag1 = op1_r[W-1] ? W'(-op1_r) : op1_r;
  assign mag2 = op2_r[W-1] ? W'(-op2_r) : op2_r;

  // multiplier: one HW x HW partial product per step
  logic [HW-1:0] pa, pb;
  logic [2*HW-1:0] pp;
  logic [PW+2*HW-1:0] pp_sh;
  always_comb begin
    pa = mstep_r[1] ? HW'(ma_r >> HW) : ma_r[HW-1:0];
    pb = mstep_r[0] ? HW'(mb_r >> HW) : mb_r[HW-1:0];
    pp = pa * pb;
    pp_sh = (PW+2*HW)'(pp) << (HW * (int'(mstep_r[1]) + int'(mstep_r[0])));
  end

  logic [W:0] rem_sh, rem_sub;
  assign rem_sh = {rem_r[W-1:0], num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, mb_r};

  // saturating conversion of magnitude to signed value
  function automatic logic [W:0] from_mag(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] lim;
    lim = PW'(VMAX) + PW'(neg);
    if (m > lim) from_mag = {1'b1, neg ? VMIN : VMAX};
    else from_mag = {1'b0, neg ? W'(-m[W-1:0]) : m[W-1:0]};
  endfunction

  logic [2:0] err_nxt;
  logic [W-1:0] top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= pee_pkg::ERR_NONE;
    end else begin
      err_r <= err_nxt;
      if (cmd.exec) begin
        if (op == pee_pkg::OP_DIGIT && !full) begin
          mem[cnt_r[AW-1:0]] <= dig_sat ? VMAX : dig_ext[W-1:0];
          cnt_r <= cnt_r + CW'(1);
        end else if (op != pee_pkg::OP_DIGIT && op != pee_pkg::OP_BAD && !short_stack)
          cnt_r <= cnt_r - CW'(2);
      end
      if (cmd.fin && res_ok_r) begin
        mem[cnt_r[AW-1:0]] <= res_r;
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.out_done) begin
        cnt_r <= '0;
        err_r <= pee_pkg::ERR_NONE;
      end
    end
  end

  always_comb begin
    err_nxt = err_r;
    if (err_r == pee_pkg::ERR_NONE) begin
      if (cmd.exec) begin
        case (op)
          pee_pkg::OP_DIGIT: if (full) err_nxt = pee_pkg::ERR_FULL;
                             else if (dig_sat) err_nxt = pee_pkg::ERR_SAT;
          pee_pkg::OP_BAD: err_nxt = pee_pkg::ERR_SYMBOL;
          default: begin
            if (short_stack) err_nxt = pee_pkg::ERR_UNDER;
            else if (op == pee_pkg::OP_DIV && op2_r == '0) err_nxt = pee_pkg::ERR_DIV0;
            else if (op == pee_pkg::OP_ADD && sum_w[W] != sum_w[W-1])
              err_nxt = pee_pkg::ERR_SAT;
            else if (op == pee_pkg::OP_SUB && dif_w[W] != dif_w[W-1])
              err_nxt = pee_pkg::ERR_SAT;
          end
        endcase
      end
      if (cmd.mul_step && mstep_r == 2'd3) begin
        if (from_mag(neg_r, (acc_r + PW'(pp_sh)) >> FRAC_BITS) >> W != '0)
          err_nxt = pee_pkg::ERR_SAT;
      end
      if (cmd.div_step && dcnt_r == IW'(1)) begin
        if (from_mag(neg_r, PW'({num_r[NW-2:0], !rem_sub[W]})) >> W != '0)
          err_nxt = pee_pkg::ERR_SAT;
      end
      if (cmd.fin && last_r && cnt_r == '0 && !res_ok_r) err_nxt = pee_pkg::ERR_UNDER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= symbol;
      last_r <= last;
    end
    if (cmd.rd) begin
      op1_r <= (cnt_r >= CW'(1)) ? mem[AW'(cnt_r - CW'(1))] : '0;
      op2_r <= (cnt_r >= CW'(2)) ? mem[AW'(cnt_r - CW'(2))] : '0;
    end
    if (cmd.exec) begin
      res_ok_r <= (op == pee_pkg::OP_ADD || op == pee_pkg::OP_SUB) && !short_stack;
      neg_r <= op1_r[W-1] ^ op2_r[W-1];
      ma_r <= mag1;
      mb_r <= mag2;
      acc_r <= '0;
      mstep_r <= '0;
      num_r <= NW'(mag1) << FRAC_BITS;
      rem_r <= '0;
      dcnt_r <= IW'(NW);
      if (!short_stack) begin
        case (op)
          pee_pkg::OP_ADD:
            res_r <= (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? VMIN : VMAX) : sum_w[W-1:0];
          pee_pkg::OP_SUB:
            res_r <= (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? VMIN : VMAX) : dif_w[W-1:0];
          default: ;
        endcase
      end
    end
    if (cmd.mul_step) begin
      acc_r <= acc_r + PW'(pp_sh);
      mstep_r <= mstep_r + 2'd1;
      if (mstep_r == 2'd3) begin
        res_ok_r <= 1'b1;
        res_r <= W'(from_mag(neg_r, (acc_r + PW'(pp_sh)) >> FRAC_BITS));
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_sub[W] ? rem_sh : rem_sub;
      num_r <= {num_r[NW-2:0], !rem_sub[W]};
      dcnt_r <= dcnt_r - IW'(1);
      if (dcnt_r == IW'(1)) begin
        res_ok_r <= 1'b1;
        res_r <= W'(from_mag(neg_r, PW'({num_r[NW-2:0], !rem_sub[W]})));
      end
    end
    if (cmd.fin) top_r <= res_ok_r ? res_r : ((cnt_r == '0) ? '0 : mem[AW'(cnt_r - CW'(1))]);
    if (cmd.out_done) begin
      out_value_r <= top_r;
      out_error_r <= err_r;
    end
  end

  assign sts.op = op;
  assign sts.last = last_r;
  assign sts.mul_done = mstep_r == 2'd3;
  assign sts.div_done = dcnt_r == IW'(1);
  assign sts.div_zero = op2_r == '0;
  assign sts.short_stack = short_stack;
  assign res_value = out_value_r;
  assign res_error = out_error_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count above depth");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(err_r) != pee_pkg::ERR_NONE && !$past(cmd.out_done)) |-> $stable(err_r))
    else $error("sticky error changed");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_done |=> (cnt_r == '0 && err_r == pee_pkg::ERR_NONE))
    else $error("stack not cleared after result");
`endif

endmodule

### rtl/core/prefix_expression_evaluator.sv
// Top level of the prefix expression evaluator: stream ports, controller and datapath.
// Depends on pee_pkg, pee_ctrl, pee_dp.
//
//  channel | dir | payload
//  in_     | in  | tdata[7:0] symbol, tlast last
//  out_    | out | tdata[47:0] value, tuser[2:0] error
//
// Each item passes the states ST_IDLE, ST_READ, ST_EXEC and ST_FIN; * adds ST_MUL for its
// 4 partial products, / adds ST_DIV (one quotient bit per cycle).
// An item marked last adds the state ST_OUT to move its result into the output register,
// which holds it until out_tready; ST_OUT waits while an earlier result is held.
// Synchronous active-low reset, no clearing pass. Input stalls while an item is in flight.
module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,   // symbol
  input  logic in_tlast,         // last
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] out_tdata, // value
  output logic [2:0] out_tuser   // error
);

  pee_pkg::cmd_t cmd;
  pee_pkg::sts_t sts;
  logic busy;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic in_fire, out_fire, out_free;
  logic out_v_r;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_free = !out_v_r || out_tready;

  pee_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy
  );

  pee_dp #(
    .STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk, .rst_n, .symbol(in_tdata), .last(in_tlast), .cmd, .sts,
    .res_value, .res_error(out_tuser)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.out_done) out_v_r <= 1'b1;
    else if (out_fire) out_v_r <= 1'b0;
  end
  assign out_tvalid = out_v_r;
  assign out_tdata = (((VALUE_WIDTH+7)/8)*8)'($unsigned(res_value));

endmodule
